// ===== rtl/rsa_me_pkg.sv =====
// Shared types and constants of the RSA modular exponentiation engine.
package rsa_me_pkg;

  localparam int MSG_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Request operations.
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [MSG_W-1:0] message;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } rsp_t;

endpackage

// ===== rtl/rsa_modular_exponentiation_top.sv =====
// RSA modular exponentiation engine: bit-serial square-and-multiply with modular add.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   req (req_type, message)
//  rsp      out        rsp_valid / rsp_stall   rsp (value, status)
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One shared shift-and-add multiplier handles one multiplier bit per cycle to form a modular
// product. Each exponent bit costs a step, a square and, for a set bit, a multiply; the
// message is first reduced modulo n on decryption. An out-of-range encryption goes straight
// to the finish state. Reset (rst, synchronous) restores the configuration registers. A new
// item is taken while the previous result waits in rsp.
module rsa_modular_exponentiation_top #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  rsa_me_pkg::req_t                   req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output rsa_me_pkg::rsp_t                   rsp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsa_me_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsa_me_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DW = (MOD_WIDTH < rsa_me_pkg::MSG_W) ? MOD_WIDTH : rsa_me_pkg::MSG_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_MULACC = 3'd3;
  localparam logic [2:0] S_SQUARE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]    state;
  logic [DW-1:0] modulus;
  logic [DW-1:0] pub_exp;
  logic [DW-1:0] priv_exp;
  logic [DW-1:0] base;
  logic [DW-1:0] acc;
  logic [DW-1:0] expo;
  logic          res_status;
  // Shared multiplier: ma doubles each cycle, mb shifts out one bit, macc collects.
  logic [DW-1:0] ma;
  logic [DW-1:0] mb;
  logic [DW-1:0] macc;
  logic [DW-1:0] ma_next;
  logic [DW-1:0] macc_next;
  logic          mul_done;
  logic [DW-1:0] msg_in;
  logic [DW-1:0] one_mod_n;

  // (a + b) mod m for a, b below m, without growing past DW bits.
  function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b,
                                            input logic [DW-1:0] m);
    logic [DW-1:0] room;
    room = m - b;
    if (a >= room) begin
      add_mod = a - room;
    end else begin
      add_mod = a + b;
    end
  endfunction

  assign msg_in    = req.message[DW-1:0];
  assign one_mod_n = (modulus == DW'(1)) ? '0 : DW'(1);
  assign mul_done  = (mb == '0);
  assign ma_next   = add_mod(ma, ma, modulus);
  assign macc_next = mb[0] ? add_mod(macc, ma, modulus) : macc;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      modulus   <= DW'(1);
      pub_exp   <= DW'(3);
      priv_exp  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsa_me_pkg::CFG_MODULUS:  modulus  <= cfg_data[DW-1:0];
          rsa_me_pkg::CFG_PUB_EXP:  pub_exp  <= cfg_data[DW-1:0];
          rsa_me_pkg::CFG_PRIV_EXP: priv_exp <= cfg_data[DW-1:0];
          default: ;
        endcase
      end

      // The result register empties when taken and refills from the finish state.
      if (state == S_FINISH && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == rsa_me_pkg::REQ_ENCRYPT) begin
              if (msg_in >= modulus) begin
                acc        <= '0;
                res_status <= rsa_me_pkg::STATUS_RANGE;
                state      <= S_FINISH;
              end else begin
                acc        <= one_mod_n;
                res_status <= rsa_me_pkg::STATUS_OK;
                base       <= msg_in;
                expo       <= pub_exp;
                state      <= S_STEP;
              end
            end else if (modulus == '0) begin
              acc        <= '0;
              res_status <= rsa_me_pkg::STATUS_OK;
              state      <= S_FINISH;
            end else begin
              // Reduce the message by multiplying it by one modulo n.
              acc        <= one_mod_n;
              res_status <= rsa_me_pkg::STATUS_OK;
              ma         <= one_mod_n;
              mb         <= msg_in;
              macc       <= '0;
              expo       <= priv_exp;
              state      <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_done) begin
            base  <= macc;
            state <= S_STEP;
          end else begin
            ma   <= ma_next;
            macc <= macc_next;
            mb   <= mb >> 1;
          end
        end
        S_STEP: begin
          if (expo == '0) begin
            state <= S_FINISH;
          end else if (expo[0]) begin
            ma    <= acc;
            mb    <= base;
            macc  <= '0;
            state <= S_MULACC;
          end else begin
            ma    <= base;
            mb    <= base;
            macc  <= '0;
            state <= S_SQUARE;
          end
        end
        S_MULACC: begin
          if (mul_done) begin
            acc   <= macc;
            ma    <= base;
            mb    <= base;
            macc  <= '0;
            state <= S_SQUARE;
          end else begin
            ma   <= ma_next;
            macc <= macc_next;
            mb   <= mb >> 1;
          end
        end
        S_SQUARE: begin
          if (mul_done) begin
            base  <= macc;
            expo  <= expo >> 1;
            state <= S_STEP;
          end else begin
            ma   <= ma_next;
            macc <= macc_next;
            mb   <= mb >> 1;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.value  <= rsa_me_pkg::VALUE_W'(acc);
            rsp.status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An error result always carries a zero value.
  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == rsa_me_pkg::STATUS_OK || rsp.value == '0))
    else $error("error result with non-zero value");

  // A successful result lies below a non-zero modulus.
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == rsa_me_pkg::STATUS_OK && modulus != '0)
      |-> (rsp.value < rsa_me_pkg::VALUE_W'(modulus)))
    else $error("result not reduced modulo n");

  // The modular adder needs both operands below the modulus throughout a product.
  a_mul_operands: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE || state == S_MULACC || state == S_SQUARE)
      |-> (ma < modulus && macc < modulus))
    else $error("multiplier operand not reduced");

  // An accepted item always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("accepted item did not start");

endmodule
